/* rtl/grouped_mean_std_engine_defines.svh */
// Assertion helpers for the grouped statistics engine.
`ifndef GROUPED_MEAN_STD_ENGINE_DEFINES_SVH
`define GROUPED_MEAN_STD_ENGINE_DEFINES_SVH

// Check a property on every rising edge outside reset.
`define GMS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check that a trigger is followed by a condition in the next cycle.
`define GMS_ASSERT_NEXT(lbl, trig, cond, msg) \
    `GMS_ASSERT(lbl, (trig) |=> (cond), msg)

`endif

/* rtl/gms_pkg.sv */
`timescale 1ns / 1ps

package gms_pkg;

    localparam int MAX_GROUPS  = 32;
    localparam int MAX_SAMPLES = 64;
    localparam int GW          = $clog2(MAX_GROUPS);
    localparam int KW          = $clog2(MAX_SAMPLES);
    localparam int AW          = GW + KW;
    localparam int DEPTH       = MAX_GROUPS * MAX_SAMPLES;
    localparam int FW          = KW + 1;
    localparam int CW          = 12;
    localparam int SUMW        = 44;
    localparam int ACCW        = 76;
    localparam int ROOTW       = 32;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_FINISH = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_P1_RD,
        ST_P1_ACC,
        ST_DIV1,
        ST_P2_RD,
        ST_P2_DIFF,
        ST_P2_SQ,
        ST_DIV2,
        ST_SQRT,
        ST_EMIT
    } state_t;

endpackage

/* rtl/grouped_mean_std_engine.sv */
`timescale 1ns / 1ps
// Add and clear items are taken while idle and may follow back to back.
// A finish emits one result per open group, then the overall result; each result
// walks its samples twice through the sample memory, with a pass of the shared
// divider after each walk, then the root; an empty result stops after one walk.
// Reset (synchronous, active low) closes all groups and sets active; no clearing pass.
`include "grouped_mean_std_engine_defines.svh"

module grouped_mean_std_engine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // group_index[5:0], sample_value[37:6], zero pad
    input  logic [1:0]  s_tuser,   // operation[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // group_number[4:0], mean_value[36:5],
                                   // deviation_value[68:37], sample_count[80:69], pad
    output logic [1:0]  m_tuser,   // is_overall[0], is_empty[1]
    output logic        m_tlast
);
    import gms_pkg::*;

    state_t state_reg, state_next;

    // Sample memory, one word per (group, slot).
    logic [31:0]        mem [DEPTH];
    logic [31:0]        rd_data_reg;
    logic               rd_en, wr_en;
    logic [AW-1:0]      rd_addr, wr_addr;

    // Per-group fill counts and open count.
    logic [FW-1:0]      fill_reg [MAX_GROUPS];
    logic [GW:0]        open_reg;
    logic               active_reg;

    // Walk control.
    logic [GW:0]        cur_g_reg, first_g_reg, end_g_reg;
    logic [FW-1:0]      cur_k_reg;
    logic [GW-1:0]      res_g_reg;
    logic               overall_reg;
    logic [FW-1:0]      fill_rd;
    logic               walk_done, have_sample;

    // Arithmetic.
    logic signed [SUMW-1:0] sum_reg;
    logic [CW-1:0]          cnt_reg;
    logic [ACCW-1:0]        acc_reg;
    logic [31:0]            diff_reg;
    logic [63:0]            sq_prod;
    logic signed [31:0]     mean_reg;
    logic [31:0]            dev_reg;
    logic                   neg_reg;

    logic [ACCW-1:0]        dq_reg, dq_step;
    logic [CW-1:0]          drem_reg, drem_step;
    logic [CW:0]            dtry;
    logic [6:0]             dcnt_reg;
    logic                   div_last;

    logic [63:0]            sval_reg;
    logic [ROOTW:0]         srem_reg, srem_step;
    logic [ROOTW-1:0]       root_reg, root_step;
    logic [ROOTW+2:0]       stry, strial;
    logic [4:0]             scnt_reg;

    logic                   in_fire, is_add, is_fin, is_clr;
    logic [5:0]             idx;
    logic [GW:0]            open_add;
    logic                   store_ok;
    logic [SUMW-1:0]        sum_mag;
    logic signed [32:0]     diff_s;

    assign in_fire = s_tvalid && s_tready;
    assign idx     = s_tdata[5:0];
    assign is_add  = in_fire && active_reg && (op_t'(s_tuser) == OP_ADD);
    assign is_fin  = in_fire && active_reg && (op_t'(s_tuser) == OP_FINISH);
    assign is_clr  = in_fire && active_reg && (op_t'(s_tuser) == OP_CLEAR);

    // One fill read port: the incoming item in idle, the walk otherwise.
    assign fill_rd = (state_reg == ST_IDLE) ? fill_reg[idx[GW-1:0]]
                                            : fill_reg[cur_g_reg[GW-1:0]];

    // Open a group when the index is at or beyond the open count and groups remain.
    always_comb begin
        open_add = open_reg;
        if ({1'b0, idx} >= 7'(open_reg) && open_reg < (GW+1)'(MAX_GROUPS)) begin
            open_add = open_reg + 1'b1;
        end
    end

    assign store_ok = ({1'b0, idx} < 7'(open_add)) && (idx < 6'(MAX_GROUPS))
                    && (fill_rd < FW'(MAX_SAMPLES));
    assign wr_en    = is_add && store_ok;
    assign wr_addr  = {idx[GW-1:0], fill_rd[KW-1:0]};

    assign walk_done   = cur_g_reg >= end_g_reg;
    assign have_sample = cur_k_reg < fill_rd;
    assign rd_addr     = {cur_g_reg[GW-1:0], cur_k_reg[KW-1:0]};

    // Shared restoring divider step, divisor is the sample count.
    assign dtry      = {drem_reg, dq_reg[ACCW-1]};
    assign drem_step = (dtry >= {1'b0, cnt_reg}) ? CW'(dtry - {1'b0, cnt_reg})
                                                 : dtry[CW-1:0];
    assign dq_step   = {dq_reg[ACCW-2:0], dtry >= {1'b0, cnt_reg}};
    assign div_last  = dcnt_reg == 7'(ACCW - 1);

    // Digit-by-digit square root step, two radicand bits per cycle.
    assign stry      = {srem_reg, sval_reg[63:62]};
    assign strial    = {1'b0, root_reg, 2'b01};
    assign srem_step = (stry >= strial) ? (ROOTW+1)'(stry - strial) : stry[ROOTW:0];
    assign root_step = {root_reg[ROOTW-2:0], stry >= strial};

    assign sum_mag = sum_reg[SUMW-1] ? SUMW'(-sum_reg) : sum_reg;
    assign diff_s  = 33'(signed'(rd_data_reg)) - 33'(mean_reg);
    // Distance magnitude stays below 2^32, so a 32 by 32 product suffices.
    assign sq_prod = diff_reg * diff_reg;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (is_fin) state_next = ST_P1_RD;
            ST_P1_RD: begin
                if (walk_done) begin
                    state_next = (cnt_reg == '0) ? ST_EMIT : ST_DIV1;
                end else if (have_sample) begin
                    state_next = ST_P1_ACC;
                end
            end
            ST_P1_ACC:  state_next = ST_P1_RD;
            ST_DIV1:    if (div_last) state_next = ST_P2_RD;
            ST_P2_RD: begin
                if (walk_done) begin
                    state_next = ST_DIV2;
                end else if (have_sample) begin
                    state_next = ST_P2_DIFF;
                end
            end
            ST_P2_DIFF: state_next = ST_P2_SQ;
            ST_P2_SQ:   state_next = ST_P2_RD;
            ST_DIV2:    if (div_last) state_next = ST_SQRT;
            ST_SQRT:    if (scnt_reg == 5'(ROOTW - 1)) state_next = ST_EMIT;
            ST_EMIT: begin
                if (m_tready) state_next = overall_reg ? ST_IDLE : ST_P1_RD;
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // Handshake and memory read strobe.
    always_comb begin
        s_tready = state_reg == ST_IDLE;
        m_tvalid = state_reg == ST_EMIT;
        rd_en    = ((state_reg == ST_P1_RD) || (state_reg == ST_P2_RD))
                 && !walk_done && have_sample;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) active_reg <= 1'b1;
        else if (cfg_we) active_reg <= cfg_wdata;
    end

    // Memory ports.
    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= s_tdata[37:6];
    end

    always_ff @(posedge aclk) begin
        if (rd_en) rd_data_reg <= mem[rd_addr];
    end

    // Group bookkeeping.
    always_ff @(posedge aclk) begin
        if (!aresetn || is_clr) begin
            open_reg <= '0;
            for (int i = 0; i < MAX_GROUPS; i++) fill_reg[i] <= '0;
        end else if (is_add) begin
            open_reg <= open_add;
            if (store_ok) fill_reg[idx[GW-1:0]] <= fill_rd + 1'b1;
        end
    end

    // Walk and arithmetic datapath.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            overall_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (is_fin) begin
                        sum_reg     <= '0;
                        cnt_reg     <= '0;
                        cur_k_reg   <= '0;
                        res_g_reg   <= '0;
                        cur_g_reg   <= '0;
                        first_g_reg <= '0;
                        // Without open groups go straight to the overall result.
                        overall_reg <= open_reg == '0;
                        end_g_reg   <= (open_reg == '0) ? '0 : (GW+1)'(1);
                    end
                end
                ST_P1_RD, ST_P2_RD: begin
                    if (walk_done) begin
                        if (state_reg == ST_P1_RD) begin
                            dq_reg   <= ACCW'(sum_mag);
                            neg_reg  <= sum_reg[SUMW-1];
                            mean_reg <= '0;
                            dev_reg  <= '0;
                        end else begin
                            dq_reg <= acc_reg;
                        end
                        drem_reg <= '0;
                        dcnt_reg <= '0;
                    end else if (have_sample) begin
                        cur_k_reg <= cur_k_reg + 1'b1;
                    end else begin
                        cur_g_reg <= cur_g_reg + 1'b1;
                        cur_k_reg <= '0;
                    end
                end
                ST_P1_ACC: begin
                    sum_reg <= sum_reg + SUMW'(signed'(rd_data_reg));
                    cnt_reg <= cnt_reg + 1'b1;
                end
                ST_DIV1: begin
                    dq_reg   <= dq_step;
                    drem_reg <= drem_step;
                    dcnt_reg <= dcnt_reg + 1'b1;
                    if (div_last) begin
                        // Truncate toward zero: divide magnitudes, restore sign.
                        mean_reg  <= neg_reg ? -dq_step[31:0] : dq_step[31:0];
                        cur_g_reg <= first_g_reg;
                        cur_k_reg <= '0;
                        acc_reg   <= '0;
                    end
                end
                ST_P2_DIFF: diff_reg <= diff_s[32] ? 32'(-diff_s) : diff_s[31:0];
                ST_P2_SQ:   acc_reg <= acc_reg + ACCW'(sq_prod);
                ST_DIV2: begin
                    dq_reg   <= dq_step;
                    drem_reg <= drem_step;
                    dcnt_reg <= dcnt_reg + 1'b1;
                    if (div_last) begin
                        sval_reg <= dq_step[63:0];
                        srem_reg <= '0;
                        root_reg <= '0;
                        scnt_reg <= '0;
                    end
                end
                ST_SQRT: begin
                    sval_reg <= {sval_reg[61:0], 2'b00};
                    srem_reg <= srem_step;
                    root_reg <= root_step;
                    scnt_reg <= scnt_reg + 1'b1;
                    if (scnt_reg == 5'(ROOTW - 1)) dev_reg <= root_step;
                end
                ST_EMIT: begin
                    if (m_tready && !overall_reg) begin
                        sum_reg   <= '0;
                        cnt_reg   <= '0;
                        cur_k_reg <= '0;
                        if ((GW+1)'(res_g_reg) + 1'b1 < open_reg) begin
                            res_g_reg   <= res_g_reg + 1'b1;
                            cur_g_reg   <= (GW+1)'(res_g_reg) + 1'b1;
                            first_g_reg <= (GW+1)'(res_g_reg) + 1'b1;
                            end_g_reg   <= (GW+1)'(res_g_reg) + 2'd2;
                        end else begin
                            overall_reg <= 1'b1;
                            cur_g_reg   <= '0;
                            first_g_reg <= '0;
                            end_g_reg   <= open_reg;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_tdata = {7'b0, cnt_reg, dev_reg, mean_reg,
                      overall_reg ? 5'(0) : 5'(res_g_reg)};
    assign m_tuser = {cnt_reg == '0, overall_reg};
    assign m_tlast = overall_reg;

    `GMS_ASSERT(a_one_side, !(s_tready && m_tvalid), "input taken while result pending")
    `GMS_ASSERT(a_open_bound, open_reg <= (GW+1)'(MAX_GROUPS), "open count overflow")
    `GMS_ASSERT(a_last_grp, (m_tvalid && m_tlast) |-> (m_tdata[4:0] == 5'd0),
                "overall result carries a group number")
    `GMS_ASSERT_NEXT(a_fin_busy, is_fin, !s_tready, "finish did not start")
endmodule

/* test/gms_stat_checker.sv */
`timescale 1ns / 1ps

module gms_stat_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [87:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        m_tlast,
    output int          fail_count,
    output int          stats_waiting
);
    import gms_pkg::*;

    typedef struct packed {
        logic [4:0]  group_number;
        logic        is_overall;
        logic [31:0] mean_value;
        logic [31:0] deviation_value;
        logic [11:0] sample_count;
        logic        is_empty;
        logic        last;
    } group_stat_t;

    logic [31:0] samples [MAX_GROUPS][MAX_SAMPLES];
    int          fill [MAX_GROUPS];
    int          open_groups;
    logic        collecting;
    group_stat_t pending_stats [$];

    function automatic logic [127:0] floor_root(logic [127:0] v);
        logic [127:0] r;
        logic [127:0] b;
        r = '0;
        b = 128'd1 << 126;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Mean and population deviation over groups first..first+num-1.
    function automatic group_stat_t group_stats(int first, int num, int gnum, bit overall);
        group_stat_t  st;
        longint       sum;
        longint       mean;
        longint       d;
        longint       cnt;
        logic [127:0] sq_sum;
        logic [127:0] mag;
        logic [127:0] root;
        sum = 0;
        cnt = 0;
        mean = 0;
        sq_sum = '0;
        root = '0;
        for (int g = first; g < first + num; g++)
            for (int k = 0; k < fill[g]; k++) begin
                sum += longint'($signed(samples[g][k]));
                cnt++;
            end
        if (cnt != 0) begin
            mean = sum / cnt;
            for (int g = first; g < first + num; g++)
                for (int k = 0; k < fill[g]; k++) begin
                    d = longint'($signed(samples[g][k])) - mean;
                    mag = (d < 0) ? 128'(-d) : 128'(d);
                    sq_sum += mag * mag;
                end
            root = floor_root(sq_sum / 128'(cnt));
            if (root > 128'hFFFF_FFFF) root = 128'hFFFF_FFFF;
        end
        st.group_number    = gnum[4:0];
        st.is_overall      = overall;
        st.mean_value      = mean[31:0];
        st.deviation_value = root[31:0];
        st.sample_count    = cnt[11:0];
        st.is_empty        = (cnt == 0);
        st.last            = overall;
        return st;
    endfunction

    // Append one expected result at the tail of the queue.
    function automatic void enqueue_stat(group_stat_t st);
        pending_stats.insert(pending_stats.size(), st);
    endfunction

    task automatic apply_item(op_t op, logic [5:0] idx, logic [31:0] val);
        if (!collecting) return;
        unique case (op)
            OP_ADD: begin
                if (idx >= open_groups && open_groups < MAX_GROUPS) open_groups++;
                if (idx < open_groups && idx < MAX_GROUPS && fill[idx] < MAX_SAMPLES) begin
                    samples[idx][fill[idx]] = val;
                    fill[idx]++;
                end
            end
            OP_FINISH: begin
                for (int g = 0; g < open_groups; g++)
                    enqueue_stat(group_stats(g, 1, g, 1'b0));
                enqueue_stat(group_stats(0, open_groups, 0, 1'b1));
            end
            OP_CLEAR: begin
                foreach (fill[g]) fill[g] = 0;
                open_groups = 0;
            end
            default: ;
        endcase
    endtask

    function automatic void report(group_stat_t e, group_stat_t a);
        fail_count++;
        if (fail_count <= 10)
            $display("mismatch: expected grp=%0d ovr=%0b mean=%h dev=%h cnt=%0d ",
                     e.group_number, e.is_overall, e.mean_value, e.deviation_value,
                     e.sample_count,
                     "emp=%0b last=%0b, got grp=%0d ovr=%0b mean=%h dev=%h ",
                     e.is_empty, e.last,
                     a.group_number, a.is_overall, a.mean_value, a.deviation_value,
                     "cnt=%0d emp=%0b last=%0b",
                     a.sample_count, a.is_empty, a.last);
    endfunction

    always @(posedge aclk) begin
        group_stat_t got;
        group_stat_t want;
        if (!aresetn) begin
            foreach (fill[g]) fill[g] = 0;
            open_groups = 0;
            collecting = 1'b1;
            pending_stats.delete();
            stats_waiting = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.group_number    = m_tdata[4:0];
                got.mean_value      = m_tdata[36:5];
                got.deviation_value = m_tdata[68:37];
                got.sample_count    = m_tdata[80:69];
                got.is_overall      = m_tuser[0];
                got.is_empty        = m_tuser[1];
                got.last            = m_tlast;
                if (pending_stats.size() == 0) begin
                    want = '0;
                    report(want, got);
                end else begin
                    want = pending_stats.pop_front();
                    if (got !== want) report(want, got);
                end
            end
            if (s_tvalid && s_tready)
                apply_item(op_t'(s_tuser), s_tdata[5:0], s_tdata[37:6]);
            if (cfg_we) collecting = cfg_wdata;
            stats_waiting = pending_stats.size();
        end
    end

endmodule

/* test/tb_grouped_mean_std_engine.sv */
`timescale 1ns / 1ps

module tb_grouped_mean_std_engine;
    import gms_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [1:0]  s_tuser = OP_ADD;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    int fail_count;
    int stats_waiting;
    int open_seen;     // rough count of open groups, used only to shape stimulus
    int drain_wait;
    bit steady;        // when set, neither side idles

    always #1 aclk = ~aclk;

    grouped_mean_std_engine dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    gms_stat_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .fail_count    (fail_count),
        .stats_waiting (stats_waiting)
    );

    // Result side: hold tready low for a random number of cycles after each item.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready = 1'b0;
        end else if (drain_wait > 0) begin
            m_tready = 1'b0;
            drain_wait--;
        end else begin
            m_tready = 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (m_tvalid && m_tready)
            drain_wait = steady ? 0 : $urandom_range(0, 8);
    end

    // Present one item after a random gap and hold it until the handshake.
    task automatic send_item(op_t op, logic [5:0] idx, logic [31:0] val);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {2'b00, val, idx};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        s_tvalid = 1'b0;
        if (op == OP_ADD && idx >= open_seen && open_seen < MAX_GROUPS) open_seen++;
        if (op == OP_CLEAR) open_seen = 0;
    endtask

    // Write the enable register once all results are out and the block has settled.
    task automatic write_active(logic value);
        wait (stats_waiting == 0);
        repeat (40) @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_we    = 1'b0;
    endtask

    function automatic logic [31:0] pick_sample();
        case ($urandom_range(0, 5))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return $urandom_range(0, 255) << 16;      // small whole values
            3:       return 32'($signed($urandom_range(0, 2000)) - 1000);
            default: return $urandom;
        endcase
    endfunction

    task automatic random_item();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
            // mostly indexes of open groups or the next one, sometimes any index up to 63
            if ($urandom_range(0, 9) == 0)
                send_item(OP_ADD, 6'($urandom_range(0, 63)), pick_sample());
            else
                send_item(OP_ADD, 6'($urandom_range(0, open_seen)), pick_sample());
        end else if (pick < 90) begin
            send_item(OP_FINISH, 6'($urandom), $urandom);
        end else if (pick < 96 || open_seen > 10) begin
            send_item(OP_CLEAR, 6'($urandom), $urandom);
        end else begin
            send_item(OP_NONE, 6'($urandom), $urandom);
        end
    endtask

    initial begin
        drain_wait = 0;
        open_seen  = 0;
        steady     = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: extremes, every operation, special cases.
        send_item(OP_FINISH, 6'd0, 32'd0);              // no groups at all
        send_item(OP_ADD, 6'd0, 32'h8000_0000);
        send_item(OP_ADD, 6'd0, 32'h7FFF_FFFF);
        send_item(OP_ADD, 6'd0, 32'h8000_0000);
        send_item(OP_ADD, 6'd1, 32'h0000_0000);
        send_item(OP_ADD, 6'd5, 32'h0001_0000);         // opens group 2 empty, dropped
        send_item(OP_ADD, 6'd1, 32'hFFFF_FFFF);
        send_item(OP_NONE, 6'h3F, 32'hFFFF_FFFF);       // unused code
        send_item(OP_FINISH, 6'h3F, 32'hFFFF_FFFF);
        send_item(OP_ADD, 6'd63, 32'h1234_5678);        // opens group 3 empty
        send_item(OP_ADD, 6'd2, 32'hFFFE_0000);
        send_item(OP_FINISH, 6'd0, 32'd0);              // finish keeps samples
        send_item(OP_FINISH, 6'd0, 32'd0);
        send_item(OP_CLEAR, 6'd0, 32'd0);
        send_item(OP_FINISH, 6'd0, 32'd0);
        send_item(OP_ADD, 6'd0, 32'h0000_0003);
        send_item(OP_ADD, 6'd0, 32'hFFFF_FFFE);
        send_item(OP_FINISH, 6'd0, 32'd0);

        // Inactive: drop everything, then re-enable.
        write_active(1'b0);
        send_item(OP_ADD, 6'd0, 32'h0100_0000);
        send_item(OP_FINISH, 6'd0, 32'd0);
        send_item(OP_CLEAR, 6'd0, 32'd0);
        write_active(1'b1);
        send_item(OP_FINISH, 6'd0, 32'd0);

        // Fill one group past its capacity.
        steady = 1'b1;
        send_item(OP_CLEAR, 6'd0, 32'd0);
        repeat (MAX_SAMPLES + 2) send_item(OP_ADD, 6'd0, pick_sample());
        send_item(OP_FINISH, 6'd0, 32'd0);
        steady = 1'b0;

        // Open every group, then try to open more.
        send_item(OP_CLEAR, 6'd0, 32'd0);
        repeat (MAX_GROUPS + 1) send_item(OP_ADD, 6'd63, pick_sample());
        send_item(OP_ADD, 6'd31, pick_sample());
        send_item(OP_ADD, 6'd40, pick_sample());
        send_item(OP_ADD, 6'd32, pick_sample());
        send_item(OP_FINISH, 6'd0, 32'd0);
        send_item(OP_CLEAR, 6'd0, 32'd0);

        // Random phases, with a burst of steady traffic and a disabled stretch.
        repeat (20) random_item();
        steady = 1'b1;
        repeat (10) random_item();
        steady = 1'b0;
        write_active(1'b0);
        repeat (10) random_item();
        write_active(1'b1);
        repeat (10) random_item();
        send_item(OP_FINISH, 6'd0, 32'd0);

        wait (stats_waiting == 0);
        repeat (200) @(posedge aclk);
        if (fail_count == 0) begin
            $display("[grouped_mean_std_engine] OK");
        end else begin
            $display("[grouped_mean_std_engine] ERROR");
        end
        $finish;
    end

    initial begin
        #40000000;
        $display("[grouped_mean_std_engine] ERROR");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/gms_pkg.sv
rtl/grouped_mean_std_engine.sv
test/gms_stat_checker.sv
test/tb_grouped_mean_std_engine.sv
